// ===== sv/frb_pkg.sv =====
// Shared types, codes and constants of the flat-bottom restraint block.
package frb_pkg;

    // Fraction bits of coordinates, force, energy and virial.
    localparam int FRAC_BITS = 20;
    // Fraction bits of the spring constant.
    localparam int K_FRAC = 12;
    // Number of low atom index bits that are passed through.
    localparam int INDEX_BITS = 24;
    // Two radicand bits per square root step over a 68-bit padded radicand.
    localparam int SQRT_STEPS = 34;
    // One quotient bit per divide step over the 102-bit numerator.
    localparam int DIV_STEPS = 102;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic [23:0]        atom_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
        logic [31:0]        spring_constant;
        logic signed [31:0] radius;
        logic [2:0]         geometry;
        logic               last_restraint;
    } t_in;

    typedef struct packed {
        logic [23:0]        atom_out;
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic [62:0]        item_energy;
        logic [62:0]        total_energy;
        logic signed [63:0] virial_xx;
        logic signed [63:0] virial_yy;
        logic signed [63:0] virial_zz;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLASS, ST_SQ, ST_MUL_LO, ST_MUL_HI, ST_SQ_ADD, ST_RR, ST_RR_SET,
        ST_SPH_CHK, ST_SQRT, ST_EMAG, ST_EN_A, ST_EN_B, ST_EN_SET, ST_SK, ST_SK_SET,
        ST_F_A, ST_F_B, ST_DIV_INIT, ST_DIV, ST_F_SET, ST_VIR, ST_VIR_SET, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MLOAD, OP_MLO, OP_MHI, OP_ADD_DR2, OP_SET_RFB2,
        OP_SQRT_INIT, OP_SQRT_STEP, OP_EMAG_SPH, OP_EMAG_SLAB, OP_SET_EN,
        OP_SET_F_SLAB, OP_DIV_INIT, OP_DIV_STEP, OP_SET_F_DIV, OP_SET_VIR, OP_EMIT
    } t_op;

    // Operand pairs that the shared multiplier can be loaded with.
    typedef enum logic [2:0] {
        MS_EE, MS_ACCK, MS_EDX, MS_FDX, MS_DXDX, MS_RR, MS_EK
    } t_msel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        logic [1:0] m;
    } t_cmd;

    typedef struct packed {
        logic is_sph;
        logic is_slab;
        logic slab_hit;
        logic sph_hit;
        logic m_is_axis;
    } t_status;

endpackage

// ===== sv/frb_ctrl.sv =====
// Sequencer that steps the restraint datapath through one item.
module frb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  frb_pkg::t_status i_status,
    output frb_pkg::t_cmd    o_cmd
);

    frb_pkg::t_state             r_state, n_state, r_after, n_after;
    logic [1:0]                  r_m, n_m;
    logic [frb_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= frb_pkg::ST_IDLE;
            r_after  <= frb_pkg::ST_IDLE;
            r_m      <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_m      <= n_m;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_m        = r_m;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid;
        o_in_ready = 1'b0;
        o_cmd.op   = frb_pkg::OP_NONE;
        o_cmd.msel = frb_pkg::MS_EE;
        o_cmd.m    = r_m;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            frb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = frb_pkg::OP_LOAD;
                    n_state  = frb_pkg::ST_CLASS;
                end
            end
            frb_pkg::ST_CLASS: begin
                n_m = 2'd0;
                if (i_status.is_sph) begin
                    n_state = frb_pkg::ST_SQ;
                end else if (i_status.slab_hit) begin
                    o_cmd.op = frb_pkg::OP_EMAG_SLAB;
                    n_state  = frb_pkg::ST_EN_A;
                end else begin
                    n_state = frb_pkg::ST_VIR;
                end
            end
            frb_pkg::ST_SQ: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_DXDX;
                n_after    = frb_pkg::ST_SQ_ADD;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_MUL_LO: begin
                o_cmd.op = frb_pkg::OP_MLO;
                n_state  = frb_pkg::ST_MUL_HI;
            end
            frb_pkg::ST_MUL_HI: begin
                o_cmd.op = frb_pkg::OP_MHI;
                n_state  = r_after;
            end
            frb_pkg::ST_SQ_ADD: begin
                o_cmd.op = frb_pkg::OP_ADD_DR2;
                if (r_m == 2'd2) begin
                    n_state = frb_pkg::ST_RR;
                end else begin
                    n_m     = r_m + 2'd1;
                    n_state = frb_pkg::ST_SQ;
                end
            end
            frb_pkg::ST_RR: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_RR;
                n_after    = frb_pkg::ST_RR_SET;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_RR_SET: begin
                o_cmd.op = frb_pkg::OP_SET_RFB2;
                n_state  = frb_pkg::ST_SPH_CHK;
            end
            frb_pkg::ST_SPH_CHK: begin
                n_cnt = '0;
                n_m   = 2'd0;
                if (i_status.sph_hit) begin
                    o_cmd.op = frb_pkg::OP_SQRT_INIT;
                    n_state  = frb_pkg::ST_SQRT;
                end else begin
                    n_state = frb_pkg::ST_VIR;
                end
            end
            frb_pkg::ST_SQRT: begin
                o_cmd.op = frb_pkg::OP_SQRT_STEP;
                if (r_cnt == frb_pkg::CNT_W'(frb_pkg::SQRT_STEPS - 1)) begin
                    n_state = frb_pkg::ST_EMAG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            frb_pkg::ST_EMAG: begin
                o_cmd.op = frb_pkg::OP_EMAG_SPH;
                n_state  = frb_pkg::ST_EN_A;
            end
            frb_pkg::ST_EN_A: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_EE;
                n_after    = frb_pkg::ST_EN_B;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_EN_B: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_ACCK;
                n_after    = frb_pkg::ST_EN_SET;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_EN_SET: begin
                o_cmd.op = frb_pkg::OP_SET_EN;
                n_m      = 2'd0;
                if (i_status.is_slab) begin
                    n_state = frb_pkg::ST_SK;
                end else begin
                    n_state = frb_pkg::ST_F_A;
                end
            end
            frb_pkg::ST_SK: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_EK;
                n_after    = frb_pkg::ST_SK_SET;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_SK_SET: begin
                o_cmd.op = frb_pkg::OP_SET_F_SLAB;
                n_m      = 2'd0;
                n_state  = frb_pkg::ST_VIR;
            end
            frb_pkg::ST_F_A: begin
                if (i_status.m_is_axis) begin
                    if (r_m == 2'd2) begin
                        n_m     = 2'd0;
                        n_state = frb_pkg::ST_VIR;
                    end else begin
                        n_m = r_m + 2'd1;
                    end
                end else begin
                    o_cmd.op   = frb_pkg::OP_MLOAD;
                    o_cmd.msel = frb_pkg::MS_EDX;
                    n_after    = frb_pkg::ST_F_B;
                    n_state    = frb_pkg::ST_MUL_LO;
                end
            end
            frb_pkg::ST_F_B: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_ACCK;
                n_after    = frb_pkg::ST_DIV_INIT;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_DIV_INIT: begin
                o_cmd.op = frb_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = frb_pkg::ST_DIV;
            end
            frb_pkg::ST_DIV: begin
                o_cmd.op = frb_pkg::OP_DIV_STEP;
                if (r_cnt == frb_pkg::CNT_W'(frb_pkg::DIV_STEPS - 1)) begin
                    n_state = frb_pkg::ST_F_SET;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            frb_pkg::ST_F_SET: begin
                o_cmd.op = frb_pkg::OP_SET_F_DIV;
                if (r_m == 2'd2) begin
                    n_m     = 2'd0;
                    n_state = frb_pkg::ST_VIR;
                end else begin
                    n_m     = r_m + 2'd1;
                    n_state = frb_pkg::ST_F_A;
                end
            end
            frb_pkg::ST_VIR: begin
                o_cmd.op   = frb_pkg::OP_MLOAD;
                o_cmd.msel = frb_pkg::MS_FDX;
                n_after    = frb_pkg::ST_VIR_SET;
                n_state    = frb_pkg::ST_MUL_LO;
            end
            frb_pkg::ST_VIR_SET: begin
                o_cmd.op = frb_pkg::OP_SET_VIR;
                if (r_m == 2'd2) begin
                    n_state = frb_pkg::ST_DONE;
                end else begin
                    n_m     = r_m + 2'd1;
                    n_state = frb_pkg::ST_VIR;
                end
            end
            frb_pkg::ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = frb_pkg::OP_EMIT;
                    n_ovalid = 1'b1;
                    n_state  = frb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// ===== sv/frb_dp.sv =====
// Datapath: shared multiplier, square root and divide units, sums and result register.
module frb_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frb_pkg::t_in     i_in,
    input  frb_pkg::t_cmd    i_cmd,
    output frb_pkg::t_status o_status,
    output frb_pkg::t_out    o_out
);

    localparam logic [62:0] SAT_POS = '1;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    logic [23:0]        r_atom;
    logic signed [32:0] r_dx [3];
    logic [32:0]        r_dxmag [3];
    logic               r_dxneg [3];
    logic [31:0]        r_rfb;
    logic               r_inv;
    logic [31:0]        r_k;
    logic [2:0]         r_geom;
    logic               r_last;
    logic [65:0]        r_dr2, r_rfb2;
    logic [67:0]        r_rad;
    logic [35:0]        r_rem;
    logic [33:0]        r_root;
    logic [33:0]        r_emag;
    logic               r_eneg, r_epos;
    logic [67:0]        r_ma;
    logic [33:0]        r_mb;
    logic [101:0]       r_acc;
    logic [101:0]       r_num;
    logic [45:0]        r_den, r_drem;
    logic [63:0]        r_q;
    logic               r_qovf;
    logic [62:0]        r_en;
    logic [62:0]        r_fmag [3];
    logic               r_fneg [3];
    logic signed [63:0] r_vir [3];
    logic [62:0]        r_esum;
    logic signed [63:0] r_vsum [3];
    frb_pkg::t_out      r_out;

    function automatic logic [62:0] sat63(input logic [101:0] v);
        sat63 = (|v[101:63]) ? SAT_POS : v[62:0];
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [62:0] mag, input logic neg);
        signed_of = neg ? (64'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    // Input conditioning.
    logic signed [32:0] in_dx [3];
    logic [23:0]        idx_mask;
    always_comb begin
        in_dx[0] = {i_in.pos_x[31], i_in.pos_x} - {i_in.ref_x[31], i_in.ref_x};
        in_dx[1] = {i_in.pos_y[31], i_in.pos_y} - {i_in.ref_y[31], i_in.ref_y};
        in_dx[2] = {i_in.pos_z[31], i_in.pos_z} - {i_in.ref_z[31], i_in.ref_z};
        for (int i = 0; i < 24; i++) begin
            idx_mask[i] = (i < frb_pkg::INDEX_BITS);
        end
    end

    // Geometry decode and slab test.
    logic [1:0]         sa;
    logic signed [33:0] sd, srs, se;
    logic               hit_hi, hit_lo, is_sph, is_slab, m_is_axis;
    always_comb begin
        is_sph  = (r_geom <= 3'd3);
        is_slab = (r_geom >= 3'd4) && (r_geom <= 3'd6);
        sa = (r_geom == 3'd6) ? 2'd2 : ((r_geom == 3'd5) ? 2'd1 : 2'd0);
        sd  = {r_dx[sa][32], r_dx[sa]};
        srs = $signed({2'b00, r_rfb});
        hit_hi = (!r_inv && sd > srs) || (r_inv && sd > 34'sd0 && sd < srs);
        hit_lo = (!r_inv && sd < -srs) || (r_inv && sd > -srs && sd < 34'sd0);
        se = hit_hi ? (sd - srs) : (sd + srs);
        m_is_axis = is_sph && (r_geom != 3'd0) && (i_cmd.m == (r_geom[1:0] - 2'd1));
        o_status.is_sph    = is_sph;
        o_status.is_slab   = is_slab;
        o_status.slab_hit  = is_slab && (hit_hi || hit_lo);
        o_status.sph_hit   = (r_dr2 != '0) &&
                             (r_inv ? (r_dr2 < r_rfb2) : (r_dr2 > r_rfb2));
        o_status.m_is_axis = m_is_axis;
    end

    // Step units.
    logic [67:0]  mul_lo, mul_hi;
    logic [37:0]  sq_sh, sq_trial;
    logic [46:0]  dv_sh;
    logic         dv_ge;
    logic [63:0]  esum_w;
    logic [62:0]  esum_new;
    logic signed [63:0] vsum_new [3];
    logic [62:0]  fdiv_mag;
    always_comb begin
        mul_lo   = r_ma[33:0] * r_mb;
        mul_hi   = r_ma[67:34] * r_mb;
        sq_sh    = {r_rem, r_rad[67:66]};
        sq_trial = {2'b00, r_root, 2'b01};
        dv_sh    = {r_drem, r_num[101]};
        dv_ge    = (dv_sh >= {1'b0, r_den});
        esum_w   = {1'b0, r_esum} + {1'b0, r_en};
        esum_new = esum_w[63] ? SAT_POS : esum_w[62:0];
        for (int i = 0; i < 3; i++) begin
            vsum_new[i] = sat_add(r_vsum[i], r_vir[i]);
        end
        fdiv_mag = (r_qovf || r_q[63]) ? SAT_POS : r_q[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum <= '0;
            for (int i = 0; i < 3; i++) begin
                r_vsum[i] <= '0;
            end
        end else if (i_cmd.op == frb_pkg::OP_EMIT) begin
            r_esum <= r_last ? '0 : esum_new;
            for (int i = 0; i < 3; i++) begin
                r_vsum[i] <= r_last ? '0 : vsum_new[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            frb_pkg::OP_LOAD: begin
                r_atom <= i_in.atom_index & idx_mask;
                for (int i = 0; i < 3; i++) begin
                    r_dx[i]    <= in_dx[i];
                    r_dxneg[i] <= in_dx[i][32];
                    r_dxmag[i] <= in_dx[i][32] ? (33'd0 - in_dx[i]) : in_dx[i];
                    r_fmag[i]  <= '0;
                    r_fneg[i]  <= 1'b0;
                    r_vir[i]   <= '0;
                end
                r_rfb  <= i_in.radius[31] ? (32'd0 - i_in.radius) : i_in.radius;
                r_inv  <= i_in.radius[31];
                r_k    <= i_in.spring_constant;
                r_geom <= i_in.geometry;
                r_last <= i_in.last_restraint;
                r_dr2  <= '0;
                r_en   <= '0;
            end
            frb_pkg::OP_MLOAD: begin
                case (i_cmd.msel)
                    frb_pkg::MS_EE: begin
                        r_ma <= {34'd0, r_emag};
                        r_mb <= r_emag;
                    end
                    frb_pkg::MS_ACCK: begin
                        r_ma <= r_acc[67:0];
                        r_mb <= {2'b00, r_k};
                    end
                    frb_pkg::MS_EDX: begin
                        r_ma <= {34'd0, r_emag};
                        r_mb <= {1'b0, r_dxmag[i_cmd.m]};
                    end
                    frb_pkg::MS_FDX: begin
                        r_ma <= {5'd0, r_fmag[i_cmd.m]};
                        r_mb <= {1'b0, r_dxmag[i_cmd.m]};
                    end
                    frb_pkg::MS_DXDX: begin
                        r_ma <= {35'd0, r_dxmag[i_cmd.m]};
                        r_mb <= {1'b0, r_dxmag[i_cmd.m]};
                    end
                    frb_pkg::MS_RR: begin
                        r_ma <= {36'd0, r_rfb};
                        r_mb <= {2'b00, r_rfb};
                    end
                    frb_pkg::MS_EK: begin
                        r_ma <= {34'd0, r_emag};
                        r_mb <= {2'b00, r_k};
                    end
                    default: begin
                        r_ma <= '0;
                        r_mb <= '0;
                    end
                endcase
            end
            frb_pkg::OP_MLO: begin
                r_acc <= {34'd0, mul_lo};
            end
            frb_pkg::OP_MHI: begin
                r_acc <= r_acc + {mul_hi, 34'd0};
            end
            frb_pkg::OP_ADD_DR2: begin
                if (!m_is_axis) begin
                    r_dr2 <= r_dr2 + r_acc[65:0];
                end
            end
            frb_pkg::OP_SET_RFB2: begin
                r_rfb2 <= r_acc[65:0];
            end
            frb_pkg::OP_SQRT_INIT: begin
                r_rad  <= {2'b00, r_dr2};
                r_rem  <= '0;
                r_root <= '0;
            end
            frb_pkg::OP_SQRT_STEP: begin
                r_rad <= {r_rad[65:0], 2'b00};
                if (sq_sh >= sq_trial) begin
                    r_rem  <= 36'(sq_sh - sq_trial);
                    r_root <= {r_root[32:0], 1'b1};
                end else begin
                    r_rem  <= 36'(sq_sh);
                    r_root <= {r_root[32:0], 1'b0};
                end
            end
            frb_pkg::OP_EMAG_SPH: begin
                if (r_root < {2'b00, r_rfb}) begin
                    r_eneg <= 1'b1;
                    r_emag <= {2'b00, r_rfb} - r_root;
                end else begin
                    r_eneg <= 1'b0;
                    r_emag <= r_root - {2'b00, r_rfb};
                end
            end
            frb_pkg::OP_EMAG_SLAB: begin
                r_emag <= se[33] ? 34'(-se) : 34'(se);
                r_epos <= !se[33] && (se != 34'sd0);
            end
            frb_pkg::OP_SET_EN: begin
                r_en <= sat63(r_acc >> (frb_pkg::K_FRAC + frb_pkg::FRAC_BITS + 1));
            end
            frb_pkg::OP_SET_F_SLAB: begin
                r_fmag[sa] <= sat63(r_acc >> frb_pkg::K_FRAC);
                r_fneg[sa] <= r_epos && (sat63(r_acc >> frb_pkg::K_FRAC) != '0);
            end
            frb_pkg::OP_DIV_INIT: begin
                r_num  <= r_acc;
                r_den  <= {r_root, 12'd0};
                r_drem <= '0;
                r_q    <= '0;
                r_qovf <= 1'b0;
            end
            frb_pkg::OP_DIV_STEP: begin
                r_num  <= {r_num[100:0], 1'b0};
                r_drem <= dv_ge ? 46'(dv_sh - {1'b0, r_den}) : dv_sh[45:0];
                r_q    <= {r_q[62:0], dv_ge};
                r_qovf <= r_qovf | r_q[63];
            end
            frb_pkg::OP_SET_F_DIV: begin
                r_fmag[i_cmd.m] <= fdiv_mag;
                r_fneg[i_cmd.m] <= (r_eneg == r_dxneg[i_cmd.m]) && (fdiv_mag != '0);
            end
            frb_pkg::OP_SET_VIR: begin
                r_vir[i_cmd.m] <= signed_of(sat63(r_acc >> (frb_pkg::FRAC_BITS + 1)),
                                            r_dxneg[i_cmd.m] == r_fneg[i_cmd.m]);
            end
            frb_pkg::OP_EMIT: begin
                r_out.atom_out     <= r_atom;
                r_out.force_x      <= signed_of(r_fmag[0], r_fneg[0]);
                r_out.force_y      <= signed_of(r_fmag[1], r_fneg[1]);
                r_out.force_z      <= signed_of(r_fmag[2], r_fneg[2]);
                r_out.item_energy  <= r_en;
                r_out.total_energy <= esum_new;
                r_out.virial_xx    <= vsum_new[0];
                r_out.virial_yy    <= vsum_new[1];
                r_out.virial_zz    <= vsum_new[2];
            end
            default: begin
            end
        endcase
    end

    assign o_out = r_out;

endmodule

// ===== sv/flat_bottom_restraint_force.sv =====
// Top level of the flat-bottomed position restraint force block.
//
// Usage: one restraint enters per transfer on the input channel (i_in_valid,
// o_in_ready, i_in) and yields exactly one result transfer on the output
// channel (o_out_valid, i_out_ready, o_out), in order. The result carries
// the force, the energy of this restraint and the running energy and virial
// sums including it. A restraint marked last clears the sums after its
// result has been formed.
// A sphere or cylinder hit runs the 34-step square root and one 102-step bit-serial
// division per force component off the cylinder axis; every product is formed from
// 34 by 34 bit halves on the shared multiplier operands. Only one restraint is in
// the block at a time; the sequencer is idle again in the cycle after the result
// is loaded.
// Reset (synchronous, active low) empties the output register, returns the
// sequencer to idle and clears the energy and virial sums.
// Receiver stall: the result waits in the output register while the next
// restraint is accepted and computed; only its final load waits for the
// register to free up.
module flat_bottom_restraint_force (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  frb_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output frb_pkg::t_out o_out
);

    frb_pkg::t_cmd    cmd;
    frb_pkg::t_status status;

    frb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    frb_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule
